// ===== hw/rtl/sef_pkg.sv =====
// sef_pkg: shared types and constants for the stereo envelope follower
// depends on nothing; imported by every module of the block

package sef_pkg;

  localparam int SEF_NUM_CHANNELS = 2;
  localparam int CFG_IDX_W        = 3;

  localparam logic [15:0] PRE_GAIN_RST  = 16'd4096;
  localparam logic [31:0] ONE_Q24       = 32'd16777216;
  localparam logic [31:0] OUT_RANGE_RST = ONE_Q24;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRE_GAIN     = 3'd0,
    REG_ATTACK_COEF  = 3'd1,
    REG_RELEASE_COEF = 3'd2,
    REG_OUT_START    = 3'd3,
    REG_OUT_RANGE    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic        channel;
    logic [15:0] sample;
  } sef_in_t;

  typedef struct packed {
    logic        out_channel;
    logic [31:0] mapped_value;
    logic [31:0] envelope;
  } sef_out_t;

  typedef struct packed {
    logic [15:0] pre_gain;
    logic [15:0] attack_coef;
    logic [15:0] release_coef;
    logic [31:0] out_start;
    logic [31:0] out_range;
  } sef_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN,
    ST_SQUARE,
    ST_DIFF,
    ST_SCALE,
    ST_UPDATE,
    ST_MAP,
    ST_SUM
  } sef_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_GAIN,
    OP_SQUARE,
    OP_DIFF,
    OP_SCALE,
    OP_UPDATE,
    OP_MAP,
    OP_SUM
  } sef_op_t;

  typedef struct packed {
    sef_op_t op;
    logic    out_load;
  } sef_cmd_t;

endpackage

// ===== hw/rtl/sef_cfg_regs.sv =====
// sef_cfg_regs: configuration register file of the envelope follower
// depends on sef_pkg

module sef_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sef_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output sef_pkg::sef_cfg_t             cfg
);
  import sef_pkg::*;

  sef_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pre_gain     <= PRE_GAIN_RST;
      cfg_r.attack_coef  <= '0;
      cfg_r.release_coef <= '0;
      cfg_r.out_start    <= '0;
      cfg_r.out_range    <= OUT_RANGE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRE_GAIN:     cfg_r.pre_gain     <= cfg_data[15:0];
        REG_ATTACK_COEF:  cfg_r.attack_coef  <= cfg_data[15:0];
        REG_RELEASE_COEF: cfg_r.release_coef <= cfg_data[15:0];
        REG_OUT_START:    cfg_r.out_start    <= cfg_data;
        REG_OUT_RANGE:    cfg_r.out_range    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sef_dp.sv =====
// sef_dp: datapath with one shared 33x33 signed multiplier, envelope store
// and result register; depends on sef_pkg, driven by sef_ctrl commands

module sef_dp #(
  parameter int NUM_CHANNELS = sef_pkg::SEF_NUM_CHANNELS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sef_pkg::sef_cmd_t cmd,
  input  sef_pkg::sef_cfg_t cfg,
  input  sef_pkg::sef_in_t  in_data,
  output sef_pkg::sef_out_t out_data
);
  import sef_pkg::*;

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic                 ch_r;
  logic [IDX_W-1:0]     idx_r;
  logic [15:0]          mag_r;
  logic signed [65:0]   prod_r;
  logic [31:0]          pw_r;
  logic [31:0]          diff_r;
  logic                 rise_r;
  logic [31:0]          env_r;
  logic [31:0]          env_mem_r [NUM_CHANNELS];
  sef_out_t             out_r;

  logic signed [32:0]   mul_a;
  logic signed [32:0]   mul_b;
  logic signed [65:0]   mul_p;
  logic [15:0]          mag_in;
  logic [IDX_W-1:0]     idx_in;
  logic [31:0]          pw_sat;
  logic [31:0]          env_old;
  logic [31:0]          step;
  logic [31:0]          env_nxt;
  logic [24:0]          env_clamp;
  logic signed [32:0]   term;
  logic signed [33:0]   sum;
  logic [31:0]          mapped;

  assign out_data = out_r;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_GAIN: begin
        mul_a = $signed({17'd0, mag_r});
        mul_b = $signed({17'd0, cfg.pre_gain});
      end
      OP_SQUARE: begin
        mul_a = $signed({1'b0, prod_r[31:0]});
        mul_b = $signed({1'b0, prod_r[31:0]});
      end
      OP_SCALE: begin
        mul_a = $signed({17'd0, rise_r ? cfg.attack_coef : cfg.release_coef});
        mul_b = $signed({1'b0, diff_r});
      end
      OP_MAP: begin
        mul_a = $signed({8'd0, env_clamp});
        mul_b = $signed({cfg.out_range[31], cfg.out_range});
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    mag_in = in_data.sample[15] ? (~in_data.sample + 16'd1) : in_data.sample;
    if (int'(in_data.channel) < NUM_CHANNELS) begin
      idx_in = IDX_W'(in_data.channel);
    end else begin
      idx_in = IDX_W'(NUM_CHANNELS - 1);
    end
    // square is Q10.54; keep Q8.24, saturate above 32 bits
    pw_sat    = (|prod_r[63:62]) ? 32'hFFFF_FFFF : prod_r[61:30];
    env_old   = env_mem_r[idx_r];
    step      = prod_r[47:16];
    env_nxt   = rise_r ? (pw_r - step) : (pw_r + step);
    env_clamp = (env_r > ONE_Q24) ? ONE_Q24[24:0] : env_r[24:0];
    // arithmetic shift gives floor, matching the rounding of negative products
    term      = prod_r[56:24];
    sum       = 34'(signed'(cfg.out_start)) + 34'(term);
    if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
      mapped = sum[31:0];
    end else if (sum[33]) begin
      mapped = 32'h8000_0000;
    end else begin
      mapped = 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        ch_r  <= in_data.channel;
        idx_r <= idx_in;
        mag_r <= mag_in;
      end
      OP_GAIN, OP_SQUARE, OP_SCALE, OP_MAP: begin
        prod_r <= mul_p;
      end
      OP_DIFF: begin
        pw_r   <= pw_sat;
        rise_r <= pw_sat > env_old;
        diff_r <= (pw_sat > env_old) ? (pw_sat - env_old) : (env_old - pw_sat);
      end
      OP_UPDATE: begin
        env_r <= env_nxt;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_r.out_channel  <= ch_r;
      out_r.mapped_value <= mapped;
      out_r.envelope     <= env_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        env_mem_r[i] <= '0;
      end
    end else if (cmd.op == OP_UPDATE) begin
      env_mem_r[idx_r] <= env_nxt;
    end
  end

endmodule

// ===== hw/rtl/sef_ctrl.sv =====
// sef_ctrl: sequencer of the envelope follower and result valid flag
// depends on sef_pkg; issues commands to sef_dp

module sef_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output sef_pkg::sef_cmd_t cmd
);
  import sef_pkg::*;

  sef_state_t state_r;
  sef_state_t state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_GAIN;
        end
      end
      ST_GAIN: begin
        cmd.op    = OP_GAIN;
        state_nxt = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.op    = OP_SQUARE;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.op    = OP_DIFF;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.op    = OP_SCALE;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.op    = OP_UPDATE;
        state_nxt = ST_MAP;
      end
      ST_MAP: begin
        cmd.op    = OP_MAP;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.op = OP_SUM;
        // wait here until the result register can take the item
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while a result is pending");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_GAIN))
    else $error("accepted item did not start the sequence");

  a_sum_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM && out_valid_r && out_stall) |=> (state_r == ST_SUM && out_valid_r))
    else $error("finished item dropped while output stalled");
`endif

endmodule

// ===== hw/rtl/stereo_envelope_follower_unit.sv =====
// stereo_envelope_follower_unit: top level of the envelope follower
// depends on sef_pkg, sef_cfg_regs, sef_ctrl and sef_dp

// Each item is taken in IDLE and then passes the states GAIN, SQUARE, DIFF,
// SCALE, UPDATE, MAP and SUM: four passes through a single shared 33x33
// multiplier (gain, square, coefficient scale, output map) with subtract and
// saturate steps between them, and a final add-and-saturate. SUM waits while
// the output is stalled; the result is valid once loaded into the output
// register. Items are taken one at a time; the finished result sits in an
// output register, so the next item is taken while it waits. The per-channel
// envelope store clears at reset. Configuration writes are always ready and
// must only be made while the block is idle.

module stereo_envelope_follower_unit #(
  parameter int NUM_CHANNELS = sef_pkg::SEF_NUM_CHANNELS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sef_pkg::sef_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sef_pkg::sef_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sef_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import sef_pkg::*;

  sef_cfg_t cfg;
  sef_cmd_t cmd;

  sef_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sef_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  sef_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
